FILE: rtl/pwsf_pkg.sv
package pwsf_pkg;

  localparam logic [2:0] FUNC_COMPUTE = 3'd0;
  localparam logic [2:0] FUNC_STICK   = 3'd1;
  localparam logic [2:0] FUNC_XTAB    = 3'd2;
  localparam logic [2:0] FUNC_YTAB    = 3'd3;
  localparam logic [2:0] FUNC_ZTAB    = 3'd4;

  localparam logic [2:0] REG_GRID_X    = 3'd0;
  localparam logic [2:0] REG_GRID_Y    = 3'd1;
  localparam logic [2:0] REG_GRID_Z    = 3'd2;
  localparam logic [2:0] REG_Y_SPAN    = 3'd3;
  localparam logic [2:0] REG_KPHASE_RE = 3'd4;
  localparam logic [2:0] REG_KPHASE_IM = 3'd5;

  localparam int GRID_W = 7;
  localparam int LI_W   = 10;
  localparam int SXY_W  = 12;
  localparam int ZSI_W  = 16;

  typedef struct packed {
    logic [2:0] func;
    logic       err;
    logic       last;
  } ctl_t;

endpackage

FILE: rtl/plane_wave_structure_factor.sv
// A request passes the front pipelines, the queue and the back pipeline before its
// result raises m_tvalid. Throughput: one request per cycle unless the queue is full or
// the output stalls; the front divider pipelines (16 + 12 stages) and the three-step
// complex multiply pipeline each take a new request every cycle while not stalled.
// Load requests give no result and retire in order with compute requests.
// Reset (rst, synchronous) clears control state and restores the register defaults;
// the stick map and phase tables hold whatever they held and need no clearing.
module plane_wave_structure_factor
  import pwsf_pkg::*;
#(
  parameter int DENSE_NX   = 64,
  parameter int DENSE_NY   = 64,
  parameter int DENSE_NZ   = 64,
  parameter int STICKS     = 1024,
  parameter int PHASE_BITS = 18,
  localparam int IN_W  = ((LI_W + SXY_W + 2 * PHASE_BITS + ZSI_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * PHASE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // load_index, stick_xy, phase_re, phase_im, z_stick_index, zero pad
  input  logic [IN_W-1:0]       s_tdata,
  // func
  input  logic [2:0]            s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // sf_re, sf_im, zero pad
  output logic [OUT_W-1:0]      m_tdata,
  // range_error
  output logic                  m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [PHASE_BITS-1:0] cfg_data
);

  localparam int P    = PHASE_BITS;
  localparam int XA_W = $clog2(2 * DENSE_NX + 1);
  localparam int YA_W = $clog2(2 * DENSE_NY + 1);
  localparam int ZA_W = $clog2(2 * DENSE_NZ + 1);
  localparam int Q_W  = $bits(ctl_t) + XA_W + YA_W + ZA_W + LI_W + 2 * P;
  localparam logic [P-1:0] KP_ONE = P'(1) << (P - 2);

  logic [GRID_W-1:0] grid_x;
  logic [GRID_W-1:0] grid_y;
  logic [GRID_W-1:0] grid_z;
  logic [GRID_W-1:0] fft_y_span;
  logic [P-1:0]      kphase_re;
  logic [P-1:0]      kphase_im;
  logic [GRID_W-1:0] gz_eff;
  logic [GRID_W-1:0] span_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x     <= GRID_W'(64);
      grid_y     <= GRID_W'(64);
      grid_z     <= GRID_W'(64);
      fft_y_span <= GRID_W'(64);
      kphase_re  <= KP_ONE;
      kphase_im  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X:    grid_x     <= cfg_data[GRID_W-1:0];
        REG_GRID_Y:    grid_y     <= cfg_data[GRID_W-1:0];
        REG_GRID_Z:    grid_z     <= cfg_data[GRID_W-1:0];
        REG_Y_SPAN:    fft_y_span <= cfg_data[GRID_W-1:0];
        REG_KPHASE_RE: kphase_re  <= cfg_data;
        REG_KPHASE_IM: kphase_im  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gz_eff   = (grid_z == '0) ? GRID_W'(1) : grid_z;
  assign span_eff = (fft_y_span == '0) ? GRID_W'(1) : fft_y_span;

  logic            full;
  logic            empty;
  logic            push;
  logic            pop;
  ctl_t            q_ctl;
  logic [XA_W-1:0] q_ix;
  logic [YA_W-1:0] q_iy;
  logic [ZA_W-1:0] q_iz;
  logic [LI_W-1:0] q_li;
  logic [P-1:0]    q_pre;
  logic [P-1:0]    q_pim;
  logic [Q_W-1:0]  h_data;
  ctl_t            h_ctl;
  logic [XA_W-1:0] h_ix;
  logic [YA_W-1:0] h_iy;
  logic [ZA_W-1:0] h_iz;
  logic [LI_W-1:0] h_li;
  logic [P-1:0]    h_pre;
  logic [P-1:0]    h_pim;
  logic [P-1:0]    sf_re;
  logic [P-1:0]    sf_im;

  assign s_tready = !full;

  pwsf_front #(
    .DENSE_NX (DENSE_NX), .DENSE_NY (DENSE_NY), .DENSE_NZ (DENSE_NZ),
    .STICKS (STICKS), .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (!full),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .li       (s_tdata[0 +: LI_W]),
    .sxy      (s_tdata[LI_W +: SXY_W]),
    .pre      (s_tdata[LI_W+SXY_W +: P]),
    .pim      (s_tdata[LI_W+SXY_W+P +: P]),
    .zsi      (s_tdata[LI_W+SXY_W+2*P +: ZSI_W]),
    .last     (s_tlast),
    .grid_x   (grid_x),
    .grid_y   (grid_y),
    .gz       (gz_eff),
    .span     (span_eff),
    .push     (push),
    .q_ctl    (q_ctl),
    .q_ix     (q_ix),
    .q_iy     (q_iy),
    .q_iz     (q_iz),
    .q_li     (q_li),
    .q_pre    (q_pre),
    .q_pim    (q_pim)
  );

  pwsf_fifo #(.W(Q_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({q_ctl, q_ix, q_iy, q_iz, q_li, q_pre, q_pim}),
    .pop   (pop),
    .rdata (h_data),
    .full  (full),
    .empty (empty)
  );

  assign {h_ctl, h_ix, h_iy, h_iz, h_li, h_pre, h_pim} = h_data;

  pwsf_back #(
    .DENSE_NX (DENSE_NX), .DENSE_NY (DENSE_NY), .DENSE_NZ (DENSE_NZ),
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .h_ctl       (h_ctl),
    .h_ix        (h_ix),
    .h_iy        (h_iy),
    .h_iz        (h_iz),
    .h_li        (h_li),
    .h_pre       (h_pre),
    .h_pim       (h_pim),
    .pop         (pop),
    .kp_re       (kphase_re),
    .kp_im       (kphase_im),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .sf_re       (sf_re),
    .sf_im       (sf_im),
    .range_error (m_tuser),
    .last_out    (m_tlast)
  );

  assign m_tdata = OUT_W'({sf_im, sf_re});

endmodule

FILE: rtl/pwsf_ram.sv
module pwsf_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int A_W = (D > 1) ? $clog2(D) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [A_W-1:0] waddr,
  input  logic [W-1:0]   wdata,
  input  logic           re,
  input  logic [A_W-1:0] raddr,
  output logic [W-1:0]   rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pwsf_div.sv
module pwsf_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  // restoring divider, one quotient bit per stage, MSB first
  logic [NUM_W-1:0] q_r [NUM_W];
  logic [DEN_W-1:0] r_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] q_in;
    logic [NUM_W-1:0] q_nxt;
    logic [DEN_W-1:0] r_in;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   d;
    logic             ge;

    if (k == 0) begin : g_first
      assign q_in = num;
      assign r_in = '0;
    end else begin : g_next
      assign q_in = q_r[k-1];
      assign r_in = r_r[k-1];
    end

    assign t  = {r_in, q_in[NUM_W-1-k]};
    assign d  = t - {1'b0, den};
    assign ge = (t >= {1'b0, den});

    always_comb begin
      q_nxt = q_in;
      q_nxt[NUM_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_nxt;
        r_r[k] <= ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
      end
    end
  end

  assign quo = q_r[NUM_W-1];
  assign rem = r_r[NUM_W-1];

endmodule

FILE: rtl/pwsf_fifo.sv
module pwsf_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int DEPTH = 4;

  logic [W-1:0] mem [DEPTH];
  logic [1:0]   wp;
  logic [1:0]   rp;
  logic [2:0]   count;

  assign full  = (count == 3'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 2'd1;
      end
      if (pop) begin
        rp <= rp + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

FILE: rtl/pwsf_front.sv
module pwsf_front
  import pwsf_pkg::*;
#(
  parameter int DENSE_NX   = 64,
  parameter int DENSE_NY   = 64,
  parameter int DENSE_NZ   = 64,
  parameter int STICKS     = 1024,
  parameter int PHASE_BITS = 18,
  localparam int XA_W = $clog2(2 * DENSE_NX + 1),
  localparam int YA_W = $clog2(2 * DENSE_NY + 1),
  localparam int ZA_W = $clog2(2 * DENSE_NZ + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [2:0]                   func,
  input  logic [LI_W-1:0]              li,
  input  logic [SXY_W-1:0]             sxy,
  input  logic [PHASE_BITS-1:0]        pre,
  input  logic [PHASE_BITS-1:0]        pim,
  input  logic [ZSI_W-1:0]             zsi,
  input  logic                         last,
  input  logic [GRID_W-1:0]            grid_x,
  input  logic [GRID_W-1:0]            grid_y,
  input  logic [GRID_W-1:0]            gz,
  input  logic [GRID_W-1:0]            span,
  output logic                         push,
  output ctl_t                         q_ctl,
  output logic [XA_W-1:0]              q_ix,
  output logic [YA_W-1:0]              q_iy,
  output logic [ZA_W-1:0]              q_iz,
  output logic [LI_W-1:0]              q_li,
  output logic [PHASE_BITS-1:0]        q_pre,
  output logic [PHASE_BITS-1:0]        q_pim
);

  localparam int P    = PHASE_BITS;
  localparam int SB_W = 3 + 1 + LI_W + SXY_W + 2 * P;
  localparam int L1   = ZSI_W;
  localparam int L2   = SXY_W;
  localparam int PL_W = SB_W + GRID_W + 1;
  localparam int SA_W = (STICKS > 1) ? $clog2(STICKS) : 1;

  localparam logic signed [13:0] OFF_X = 14'(DENSE_NX);
  localparam logic signed [13:0] OFF_Y = 14'(DENSE_NY);
  localparam logic signed [13:0] OFF_Z = 14'(DENSE_NZ);
  localparam logic signed [13:0] MAX_X = 14'(2 * DENSE_NX);
  localparam logic signed [13:0] MAX_Y = 14'(2 * DENSE_NY);
  localparam logic signed [13:0] MAX_Z = 14'(2 * DENSE_NZ);

  function automatic logic signed [13:0] fold(input logic [11:0] c, input logic [6:0] n);
    logic signed [13:0] cs;
    cs = signed'({2'b00, c});
    if (c >= 12'(n[6:1]) + 12'd1) begin
      cs = cs - signed'({7'b0, n});
    end
    return cs;
  endfunction

  logic              in_ok;
  logic [SB_W-1:0]   sb_in;
  logic [L1-1:0]     v1;
  logic [SB_W-1:0]   sb1 [L1];
  logic [ZSI_W-1:0]  stick;
  logic [GRID_W-1:0] zrem;
  logic [2:0]        func1;
  logic [LI_W-1:0]   li1;
  logic [SXY_W-1:0]  sxy1;
  logic              smap_we;
  logic [SXY_W-1:0]  ixy;
  logic              va;
  logic [SB_W-1:0]   sba;
  logic [GRID_W-1:0] iza;
  logic              erra;
  logic [L2-1:0]     v2;
  logic [PL_W-1:0]   pl2 [L2];
  logic [SXY_W-1:0]  xq;
  logic [GRID_W-1:0] yr;
  logic [SB_W-1:0]   sbb;
  logic [GRID_W-1:0] izb;
  logic              errb;
  logic signed [13:0] fx;
  logic signed [13:0] fy;
  logic signed [13:0] fz;
  logic              okx;
  logic              oky;
  logic              okz;

  assign in_ok = in_valid && (func == FUNC_COMPUTE || func == FUNC_STICK ||
                 func == FUNC_XTAB || func == FUNC_YTAB || func == FUNC_ZTAB);
  assign sb_in = {func, last, li, sxy, pre, pim};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
      va <= 1'b0;
      v2 <= '0;
    end else if (en) begin
      v1 <= {v1[L1-2:0], in_ok};
      va <= v1[L1-1];
      v2 <= {v2[L2-2:0], va};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1[0] <= sb_in;
      for (int i = 1; i < L1; i++) begin
        sb1[i] <= sb1[i-1];
      end
      sba  <= sb1[L1-1];
      iza  <= zrem;
      erra <= (32'(stick) >= STICKS);
      pl2[0] <= {sba, iza, erra};
      for (int i = 1; i < L2; i++) begin
        pl2[i] <= pl2[i-1];
      end
    end
  end

  pwsf_div #(.NUM_W(ZSI_W), .DEN_W(GRID_W)) u_div_z (
    .clk (clk),
    .en  (en),
    .num (zsi),
    .den (gz),
    .quo (stick),
    .rem (zrem)
  );

  assign func1   = sb1[L1-1][SB_W-1 -: 3];
  assign li1     = sb1[L1-1][2*P+SXY_W +: LI_W];
  assign sxy1    = sb1[L1-1][2*P +: SXY_W];
  assign smap_we = en && v1[L1-1] && func1 == FUNC_STICK && (32'(li1) < STICKS);

  pwsf_ram #(.W(SXY_W), .D(STICKS)) u_stick_map (
    .clk   (clk),
    .we    (smap_we),
    .waddr (SA_W'(li1)),
    .wdata (sxy1),
    .re    (en),
    .raddr (SA_W'(stick)),
    .rdata (ixy)
  );

  pwsf_div #(.NUM_W(SXY_W), .DEN_W(GRID_W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (ixy),
    .den (span),
    .quo (xq),
    .rem (yr)
  );

  assign sbb  = pl2[L2-1][GRID_W+1 +: SB_W];
  assign izb  = pl2[L2-1][1 +: GRID_W];
  assign errb = pl2[L2-1][0];

  assign fx  = fold(xq, grid_x) + OFF_X;
  assign fy  = fold(12'(yr), grid_y) + OFF_Y;
  assign fz  = fold(12'(izb), gz) + OFF_Z;
  assign okx = (fx >= 14'sd0) && (fx <= MAX_X);
  assign oky = (fy >= 14'sd0) && (fy <= MAX_Y);
  assign okz = (fz >= 14'sd0) && (fz <= MAX_Z);

  assign push       = en && v2[L2-1];
  assign q_ctl.func = sbb[SB_W-1 -: 3];
  assign q_ctl.last = sbb[SB_W-4];
  assign q_ctl.err  = errb || !okx || !oky || !okz;
  assign q_ix       = fx[XA_W-1:0];
  assign q_iy       = fy[YA_W-1:0];
  assign q_iz       = fz[ZA_W-1:0];
  assign q_li       = sbb[2*P+SXY_W +: LI_W];
  assign q_pre      = sbb[P +: P];
  assign q_pim      = sbb[0 +: P];

endmodule

FILE: rtl/pwsf_back.sv
module pwsf_back
  import pwsf_pkg::*;
#(
  parameter int DENSE_NX   = 64,
  parameter int DENSE_NY   = 64,
  parameter int DENSE_NZ   = 64,
  parameter int PHASE_BITS = 18,
  localparam int XA_W = $clog2(2 * DENSE_NX + 1),
  localparam int YA_W = $clog2(2 * DENSE_NY + 1),
  localparam int ZA_W = $clog2(2 * DENSE_NZ + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  ctl_t                  h_ctl,
  input  logic [XA_W-1:0]       h_ix,
  input  logic [YA_W-1:0]       h_iy,
  input  logic [ZA_W-1:0]       h_iz,
  input  logic [LI_W-1:0]       h_li,
  input  logic [PHASE_BITS-1:0] h_pre,
  input  logic [PHASE_BITS-1:0] h_pim,
  output logic                  pop,
  input  logic [PHASE_BITS-1:0] kp_re,
  input  logic [PHASE_BITS-1:0] kp_im,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PHASE_BITS-1:0] sf_re,
  output logic [PHASE_BITS-1:0] sf_im,
  output logic                  range_error,
  output logic                  last_out
);

  localparam int P    = PHASE_BITS;
  localparam int XT_D = 2 * DENSE_NX + 1;
  localparam int YT_D = 2 * DENSE_NY + 1;
  localparam int ZT_D = 2 * DENSE_NZ + 1;

  localparam logic signed [2*P:0] HALF = (2*P+1)'(1) << (P - 3);
  localparam logic signed [P+3:0] SMAX = {5'b00000, {(P-1){1'b1}}};
  localparam logic signed [P+3:0] SMIN = {5'b11111, {(P-1){1'b0}}};

  function automatic logic signed [P+2:0] rnd(input logic signed [2*P-1:0] p);
    logic signed [2*P:0] s;
    s = (2*P+1)'(p) + HALF;
    return s[2*P:P-2];
  endfunction

  function automatic logic [P-1:0] sat(input logic signed [P+3:0] v);
    logic [P-1:0] r;
    if (v > SMAX) begin
      r = SMAX[P-1:0];
    end else if (v < SMIN) begin
      r = SMIN[P-1:0];
    end else begin
      r = v[P-1:0];
    end
    return r;
  endfunction

  // {re, im} of the rounded, saturated complex product
  function automatic logic [2*P-1:0] cround(input logic signed [2*P-1:0] rr,
                                            input logic signed [2*P-1:0] ii,
                                            input logic signed [2*P-1:0] ri,
                                            input logic signed [2*P-1:0] ir);
    logic signed [P+3:0] sr;
    logic signed [P+3:0] si;
    sr = (P+4)'(rnd(rr)) - (P+4)'(rnd(ii));
    si = (P+4)'(rnd(ri)) + (P+4)'(rnd(ir));
    return {sat(sr), sat(si)};
  endfunction

  logic           en_b;
  logic           is_cmp;
  logic           xwe;
  logic           ywe;
  logic           zwe;
  logic [2*P-1:0] xrd;
  logic [2*P-1:0] yrd;
  logic [2*P-1:0] zrd;
  logic [6:1]     v;
  ctl_t           c [1:6];
  logic [2*P-1:0] y2;
  logic [2*P-1:0] y3;
  logic [2*P-1:0] z2;
  logic [2*P-1:0] z3;
  logic [2*P-1:0] z4;
  logic [2*P-1:0] z5;
  logic signed [2*P-1:0] p2_rr, p2_ii, p2_ri, p2_ir;
  logic signed [2*P-1:0] p4_rr, p4_ii, p4_ri, p4_ir;
  logic signed [2*P-1:0] p6_rr, p6_ii, p6_ri, p6_ir;
  logic [2*P-1:0] a3;
  logic [2*P-1:0] a5;
  logic [2*P-1:0] res;

  assign en_b   = !out_valid || out_ready;
  assign pop    = en_b && !empty;
  assign is_cmp = (h_ctl.func == FUNC_COMPUTE);
  assign xwe    = pop && h_ctl.func == FUNC_XTAB && (32'(h_li) < XT_D);
  assign ywe    = pop && h_ctl.func == FUNC_YTAB && (32'(h_li) < YT_D);
  assign zwe    = pop && h_ctl.func == FUNC_ZTAB && (32'(h_li) < ZT_D);

  pwsf_ram #(.W(2*P), .D(XT_D)) u_x_tab (
    .clk (clk), .we (xwe), .waddr (XA_W'(h_li)), .wdata ({h_pre, h_pim}),
    .re (en_b), .raddr (h_ix), .rdata (xrd)
  );

  pwsf_ram #(.W(2*P), .D(YT_D)) u_y_tab (
    .clk (clk), .we (ywe), .waddr (YA_W'(h_li)), .wdata ({h_pre, h_pim}),
    .re (en_b), .raddr (h_iy), .rdata (yrd)
  );

  pwsf_ram #(.W(2*P), .D(ZT_D)) u_z_tab (
    .clk (clk), .we (zwe), .waddr (ZA_W'(h_li)), .wdata ({h_pre, h_pim}),
    .re (en_b), .raddr (h_iz), .rdata (zrd)
  );

  assign res = cround(p6_rr, p6_ii, p6_ri, p6_ir);

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en_b) begin
      v         <= {v[5:1], pop && is_cmp};
      out_valid <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      c[1] <= h_ctl;
      for (int i = 2; i <= 6; i++) begin
        c[i] <= c[i-1];
      end
      y2 <= yrd;
      y3 <= y2;
      z2 <= zrd;
      z3 <= z2;
      z4 <= z3;
      z5 <= z4;

      p2_rr <= signed'(kp_re) * signed'(xrd[2*P-1:P]);
      p2_ii <= signed'(kp_im) * signed'(xrd[P-1:0]);
      p2_ri <= signed'(kp_re) * signed'(xrd[P-1:0]);
      p2_ir <= signed'(kp_im) * signed'(xrd[2*P-1:P]);
      a3    <= cround(p2_rr, p2_ii, p2_ri, p2_ir);

      p4_rr <= signed'(a3[2*P-1:P]) * signed'(y3[2*P-1:P]);
      p4_ii <= signed'(a3[P-1:0]) * signed'(y3[P-1:0]);
      p4_ri <= signed'(a3[2*P-1:P]) * signed'(y3[P-1:0]);
      p4_ir <= signed'(a3[P-1:0]) * signed'(y3[2*P-1:P]);
      a5    <= cround(p4_rr, p4_ii, p4_ri, p4_ir);

      p6_rr <= signed'(a5[2*P-1:P]) * signed'(z5[2*P-1:P]);
      p6_ii <= signed'(a5[P-1:0]) * signed'(z5[P-1:0]);
      p6_ri <= signed'(a5[2*P-1:P]) * signed'(z5[P-1:0]);
      p6_ir <= signed'(a5[P-1:0]) * signed'(z5[2*P-1:P]);

      if (v[6]) begin
        sf_re       <= c[6].err ? '0 : res[2*P-1:P];
        sf_im       <= c[6].err ? '0 : res[P-1:0];
        range_error <= c[6].err;
        last_out    <= c[6].last;
      end
    end
  end

endmodule

FILE: rtl/pwsf_chk.sv
module pwsf_chk #(
  parameter int PHASE_BITS = 18,
  localparam int OUT_W = ((2 * PHASE_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("range error with nonzero value");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind plane_wave_structure_factor pwsf_chk #(.PHASE_BITS(PHASE_BITS)) u_pwsf_chk (.*);

FILE: tb/sv/plane_wave_structure_factor_tb.sv
module plane_wave_structure_factor_tb;
  import pwsf_pkg::*;

  localparam int NX = 64;
  localparam int NY = 64;
  localparam int NZ = 64;
  localparam int NSTICK = 1024;
  localparam int TDEPTH = 2 * NX + 1;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [2:0]  func;
    logic [9:0]  li;
    logic [11:0] sxy;
    logic [17:0] pre;
    logic [17:0] pim;
    logic [15:0] zsi;
    logic        last;
  } req_t;

  typedef struct {
    logic [17:0] re;
    logic [17:0] im;
    logic        err;
    logic        last;
  } sf_t;

  class sf_scoreboard;
    sf_t pending[$];
    int errors = 0;
    logic [11:0] stick_map[NSTICK];
    bit stick_set[NSTICK];
    longint xt[TDEPTH][2];
    longint yt[TDEPTH][2];
    longint zt[TDEPTH][2];
    int unsigned gx = 64, gy = 64, gz = 64, span = 64;
    longint kre = 65536, kim = 0;

    function void set_reg(logic [2:0] idx, logic [17:0] val);
      case (idx)
        REG_GRID_X:    gx = val[6:0];
        REG_GRID_Y:    gy = val[6:0];
        REG_GRID_Z:    gz = val[6:0];
        REG_Y_SPAN:    span = val[6:0];
        REG_KPHASE_RE: kre = longint'($signed(val));
        REG_KPHASE_IM: kim = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint rprod(longint a, longint b);
      return (a * b + 32768) >>> 16;
    endfunction

    function longint sat18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
    endfunction

    function void cmul(inout longint re, inout longint im, input longint tre, input longint tim);
      longint r, i;
      r = sat18(rprod(re, tre) - rprod(im, tim));
      i = sat18(rprod(re, tim) + rprod(im, tre));
      re = r;
      im = i;
    endfunction

    function longint fold(longint c, int unsigned n);
      if (c >= longint'(n / 2) + 1) return c - longint'(n);
      return c;
    endfunction

    function int unsigned eff_gz();
      return (gz == 0) ? 1 : gz;
    endfunction

    function bit compute_safe(logic [15:0] zsi);
      int unsigned s;
      s = zsi / eff_gz();
      return (s >= NSTICK) || stick_set[s];
    endfunction

    function void note_request(req_t r);
      int unsigned gzv, sp, s, ixy;
      longint ix, iy, iz, re, im;
      sf_t e;
      case (r.func)
        FUNC_STICK: begin
          stick_map[r.li] = r.sxy;
          stick_set[r.li] = 1'b1;
        end
        FUNC_XTAB: if (r.li < TDEPTH) begin
          xt[r.li][0] = longint'($signed(r.pre));
          xt[r.li][1] = longint'($signed(r.pim));
        end
        FUNC_YTAB: if (r.li < TDEPTH) begin
          yt[r.li][0] = longint'($signed(r.pre));
          yt[r.li][1] = longint'($signed(r.pim));
        end
        FUNC_ZTAB: if (r.li < TDEPTH) begin
          zt[r.li][0] = longint'($signed(r.pre));
          zt[r.li][1] = longint'($signed(r.pim));
        end
        FUNC_COMPUTE: begin
          gzv = eff_gz();
          sp = (span == 0) ? 1 : span;
          s = r.zsi / gzv;
          re = 0;
          im = 0;
          e.err = 1'b0;
          if (s >= NSTICK) begin
            e.err = 1'b1;
          end else begin
            ixy = stick_map[s];
            ix = fold(ixy / sp, gx) + NX;
            iy = fold(ixy % sp, gy) + NY;
            iz = fold(r.zsi % gzv, gz) + NZ;
            if (ix < 0 || ix >= TDEPTH || iy < 0 || iy >= TDEPTH ||
                iz < 0 || iz >= TDEPTH) begin
              e.err = 1'b1;
            end else begin
              re = kre;
              im = kim;
              cmul(re, im, xt[ix][0], xt[ix][1]);
              cmul(re, im, yt[iy][0], yt[iy][1]);
              cmul(re, im, zt[iz][0], zt[iz][1]);
            end
          end
          e.re = re[17:0];
          e.im = im[17:0];
          e.last = r.last;
          pending.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [17:0] re, logic [17:0] im, logic err, logic last);
      sf_t e;
      if (pending.size() == 0) begin
        $error("unexpected result re=%0h im=%0h", re, im);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $error("sf_re expected %0h actual %0h", e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $error("sf_im expected %0h actual %0h", e.im, im);
        errors++;
      end
      if (err !== e.err) begin
        $error("range_error expected %0b actual %0b", e.err, err);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_out expected %0b actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [39:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  sf_scoreboard sb = new();
  bit tx_calm = 0;
  bit rx_calm = 0;
  int cycles = 0;
  int stick_list[$];

  plane_wave_structure_factor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[plane_wave_structure_factor] ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[17:0], m_tdata[35:18], m_tuser, m_tlast);

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 0;
        repeat (gap) @(negedge clk);
        m_tready <= 1;
      end else if (!m_tready) begin
        @(negedge clk);
        m_tready <= 1;
      end
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send(req_t r);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= r.func;
    s_tlast <= r.last;
    s_tdata <= {6'b0, r.zsi, r.pim, r.pre, r.sxy, r.li};
    do @(posedge clk); while (!s_tready);
    if (r.func == FUNC_STICK && !sb.stick_set[r.li]) stick_list.push_back(int'(r.li));
    sb.note_request(r);
  endtask

  task automatic go_idle();
    @(negedge clk);
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_regs(logic [17:0] g0, logic [17:0] g1, logic [17:0] g2,
                            logic [17:0] g3, logic [17:0] kr, logic [17:0] ki);
    logic [17:0] vals[6];
    vals = '{g0, g1, g2, g3, kr, ki};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      sb.set_reg(3'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic req_t rand_req(logic [2:0] func);
    req_t r;
    r.func = func;
    r.li = 10'($urandom_range(0, 1023));
    r.sxy = 12'($urandom_range(0, 4095));
    r.pre = 18'($urandom);
    r.pim = 18'($urandom);
    r.zsi = 16'($urandom_range(0, 65535));
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t load_req(logic [2:0] func, int idx);
    req_t r;
    r = rand_req(func);
    r.li = 10'(idx);
    return r;
  endfunction

  function automatic req_t compute_req(bit wellformed);
    req_t r;
    int unsigned g, s, z;
    r = rand_req(FUNC_COMPUTE);
    if (wellformed) begin
      g = sb.eff_gz();
      s = stick_list[$urandom_range(0, stick_list.size() - 1)];
      z = $urandom_range(0, g - 1);
      if (s * g + z <= 65535) r.zsi = 16'(s * g + z);
    end
    while (!sb.compute_safe(r.zsi)) r.zsi = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic random_block(int n);
    req_t r;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70) r = compute_req(1);
      else if (k < 80) r = rand_req(FUNC_STICK);
      else if (k < 86) r = load_req(3'($urandom_range(2, 4)), $urandom_range(0, 160));
      else if (k < 90) r = rand_req(3'($urandom_range(5, 7)));
      else r = compute_req(0);
      send(r);
    end
  endtask

  initial begin
    req_t r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    for (int i = 0; i < TDEPTH; i++) begin
      send(load_req(FUNC_XTAB, i));
      send(load_req(FUNC_YTAB, i));
      send(load_req(FUNC_ZTAB, i));
    end
    for (int i = 0; i < 32; i++) send(load_req(FUNC_STICK, (i == 0) ? 0 : (i == 1) ? 1023 :
                                                      $urandom_range(0, 1023)));

    // directed: extremes, ignored loads, unknown funcs
    r = load_req(FUNC_XTAB, NX);
    r.pre = 18'h1ffff;
    r.pim = 18'h20000;
    send(r);
    r = load_req(FUNC_ZTAB, 1023);
    send(r);
    r = load_req(FUNC_YTAB, TDEPTH);
    send(r);
    r = load_req(FUNC_STICK, 5);
    r.sxy = 12'hfff;
    send(r);
    r = load_req(FUNC_STICK, 6);
    r.sxy = 12'h000;
    send(r);
    for (int f = 5; f < 8; f++) send(rand_req(3'(f)));
    r = rand_req(FUNC_COMPUTE);
    r.zsi = 16'h0000;
    r.last = 0;
    send(r);
    r.zsi = 16'hffff;
    r.last = 1;
    send(r);
    for (int s = 5; s < 7; s++) begin
      r.zsi = 16'(s * 64 + 63);
      send(r);
      r.zsi = 16'(s * 64 + 32);
      send(r);
      r.zsi = 16'(s * 64 + 33);
      send(r);
    end
    random_block(60);
    go_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_regs(18'd64, 18'd64, 18'd64, 18'd64, 18'h10000, 18'd0);
        1: write_regs(18'd1, 18'd1, 18'd1, 18'd1, 18'h1ffff, 18'h20000);
        2: write_regs(18'd0, 18'd0, 18'd0, 18'd0, 18'h20000, 18'h1ffff);
        3: write_regs(18'd127, 18'd127, 18'd127, 18'd127, 18'($urandom), 18'($urandom));
        4: write_regs(18'd64, 18'd64, 18'd64, 18'd64, 18'h20000, 18'h20000);
        default: write_regs(18'($urandom_range(1, 64)), 18'($urandom_range(1, 64)),
                            18'($urandom_range(1, 64)), 18'($urandom_range(1, 64)),
                            18'($urandom), 18'($urandom));
      endcase
      tx_calm = (p % 3 == 1);
      rx_calm = (p % 4 == 2);
      random_block(70);
      go_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[plane_wave_structure_factor] OK");
    end else begin
      $display("[plane_wave_structure_factor] ERROR");
    end
    $finish;
  end

endmodule
